// ===== rtl/bcm_pkg.sv =====
`default_nettype none

package bcm_pkg;

	localparam logic [1:0] FUNC_INIT  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_EXEC  = 2'd2;

	localparam logic [1:0] STAT_RUN      = 2'd0;
	localparam logic [1:0] STAT_HALT     = 2'd1;
	localparam logic [1:0] STAT_ILLEGAL  = 2'd2;
	localparam logic [1:0] STAT_PAST_END = 2'd3;

	localparam logic [7:0] OP_NOP   = 8'h00;
	localparam logic [7:0] OP_LOAD  = 8'h01;
	localparam logic [7:0] OP_STB   = 8'h02;
	localparam logic [7:0] OP_ADD   = 8'h03;
	localparam logic [7:0] OP_SUB   = 8'h04;
	localparam logic [7:0] OP_CMP   = 8'h08;
	localparam logic [7:0] OP_JE    = 8'h09;
	localparam logic [7:0] OP_HALT  = 8'hFF;

	typedef enum logic [1:0] {
		RF_SEL_A,
		RF_SEL_B,
		RF_SEL_OUT
	} rf_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       init_state;
		logic       clear_mem;
		logic       write_byte;
		logic       stop_past_end;
		logic [1:0] fetch_ofs;
		logic       cap_op;
		logic       cap_a;
		logic       cap_b;
		logic       cap_imm;
		logic       cap_ra;
		logic       cap_rb;
		rf_sel_t    rf_sel;
		logic       exec;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic run;
		logic pc_past_end;
		logic clear_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/byte_code_machine_step.sv =====
// Single-step bytecode machine with REG_COUNT 32-bit registers and a MEM_BYTES byte
// program memory behind one single-port RAM. Each accepted word gives exactly one result
// word. After reset the block clears its memory before in_ready first rises. An execute
// word on a running machine passes from acceptance through a dispatch state, fetch states
// that read the four instruction bytes through the single memory port and the two source
// registers, an execute state and a report state that registers the result; an execute
// on a stopped machine or at a pc past the end goes from dispatch straight to report, as
// do a program byte write and an unused function code. An init sweeps the memory one byte
// per cycle before its report. in_ready rises again in the same cycle as out_valid. A new
// word is accepted while the previous result still waits in the output register; its own
// result then waits until that one is taken.
`default_nettype none

module byte_code_machine_step
	import bcm_pkg::*;
#(
	parameter int MEM_BYTES = 4096,
	parameter int REG_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  byte_data,
	input  wire logic [2:0]  read_reg_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [12:0]      pc_value,
	output logic             equal_flag,
	output logic [31:0]      reg_value
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bcm_dp #(
		.MEM_BYTES (MEM_BYTES),
		.REG_COUNT (REG_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.address        (address),
		.byte_data      (byte_data),
		.read_reg_index (read_reg_index),
		.status         (status),
		.pc_value       (pc_value),
		.equal_flag     (equal_flag),
		.reg_value      (reg_value)
	);

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second word while one is in progress");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_mem, cmd.write_byte, cmd.exec}))
		else $error("memory port claimed by two sources");

	a_fetch_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_op |-> stat.run && !stat.pc_past_end)
		else $error("instruction fetched on a stopped machine");

endmodule

`default_nettype wire

// ===== rtl/bcm_ctrl.sv =====
`default_nettype none

module bcm_ctrl
	import bcm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_cmd_t         cmd,
	input  wire dp_stat_t   stat
);

	typedef enum logic [3:0] {
		S_BOOT,
		S_IDLE,
		S_DISPATCH,
		S_CLEAR,
		S_FETCH0,
		S_FETCH1,
		S_FETCH2,
		S_FETCH3,
		S_FETCH4,
		S_EXEC,
		S_REPORT
	} state_t;

	state_t     state_q;
	logic [1:0] func_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.rf_sel = RF_SEL_OUT;
		case (state_q)
			S_BOOT, S_CLEAR: begin
				cmd.clear_mem = 1'b1;
			end
			S_IDLE: begin
				cmd.load_in = in_valid;
			end
			S_DISPATCH: begin
				case (func_q)
					FUNC_INIT: begin
						cmd.init_state = 1'b1;
					end
					FUNC_WRITE: begin
						cmd.write_byte = 1'b1;
					end
					FUNC_EXEC: begin
						cmd.stop_past_end = stat.run && stat.pc_past_end;
					end
					default: begin
					end
				endcase
			end
			S_FETCH0: begin
				cmd.fetch_ofs = 2'd0;
			end
			S_FETCH1: begin
				cmd.fetch_ofs = 2'd1;
				cmd.cap_op = 1'b1;
			end
			S_FETCH2: begin
				cmd.fetch_ofs = 2'd2;
				cmd.cap_a = 1'b1;
			end
			S_FETCH3: begin
				cmd.fetch_ofs = 2'd3;
				cmd.cap_b = 1'b1;
				cmd.rf_sel = RF_SEL_A;
				cmd.cap_ra = 1'b1;
			end
			S_FETCH4: begin
				cmd.cap_imm = 1'b1;
				cmd.rf_sel = RF_SEL_B;
				cmd.cap_rb = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_REPORT: begin
				cmd.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			func_q      <= FUNC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_BOOT: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (func_q)
						FUNC_INIT: begin
							state_q <= S_CLEAR;
						end
						FUNC_EXEC: begin
							if (stat.run && !stat.pc_past_end) begin
								state_q <= S_FETCH0;
							end else begin
								state_q <= S_REPORT;
							end
						end
						default: begin
							state_q <= S_REPORT;
						end
					endcase
				end
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_REPORT;
					end
				end
				S_FETCH0: state_q <= S_FETCH1;
				S_FETCH1: state_q <= S_FETCH2;
				S_FETCH2: state_q <= S_FETCH3;
				S_FETCH3: state_q <= S_FETCH4;
				S_FETCH4: state_q <= S_EXEC;
				S_EXEC:   state_q <= S_REPORT;
				S_REPORT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bcm_dp.sv =====
`default_nettype none

module bcm_dp
	import bcm_pkg::*;
#(
	parameter int MEM_BYTES = 4096,
	parameter int REG_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  byte_data,
	input  wire logic [2:0]  read_reg_index,
	output logic [1:0]       status,
	output logic [12:0]      pc_value,
	output logic             equal_flag,
	output logic [31:0]      reg_value
);

	localparam int AW  = $clog2(MEM_BYTES);
	localparam int PCW = $clog2(MEM_BYTES + 4);
	localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	function automatic logic [RIW-1:0] reg_pick(input logic [2:0] b);
		logic [4:0] v;
		v = {2'b00, b};
		for (int i = 0; i < 3; i++) begin
			if (v >= 5'(REG_COUNT)) begin
				v = v - 5'(REG_COUNT);
			end
		end
		return v[RIW-1:0];
	endfunction

	logic [7:0]     mem [MEM_BYTES];
	logic [7:0]     rdata_q;
	logic           rvalid_q;
	logic [31:0]    rf [REG_COUNT];

	logic [AW-1:0]  clr_cnt_q;
	logic [PCW-1:0] pc_q;
	logic           run_q;
	logic           eq_q;
	logic [1:0]     stop_q;

	logic [11:0]    addr_q;
	logic [7:0]     byte_q;
	logic [RIW-1:0] rsel_q;
	logic [7:0]     op_q;
	logic [RIW-1:0] a_q;
	logic [RIW-1:0] b_q;
	logic [7:0]     imm_q;
	logic [31:0]    ra_q;
	logic [31:0]    rb_q;

	logic [1:0]     status_q;
	logic [12:0]    pc_out_q;
	logic           eq_out_q;
	logic [31:0]    reg_out_q;

	logic [AW+11:0] wr_ext;
	logic           wr_ok;
	logic [PCW-1:0] fetch_addr;
	logic           fetch_ok;
	logic [AW-1:0]  mem_idx;
	logic           mem_we;
	logic [7:0]     mem_wdata;
	logic [7:0]     mem_byte;
	logic [RIW-1:0] rf_addr;
	logic [31:0]    rf_rd;
	logic [PCW+12:0] pc_wide;

	assign wr_ext     = {{AW{1'b0}}, addr_q};
	assign wr_ok      = wr_ext < (AW+12)'(MEM_BYTES);
	assign fetch_addr = pc_q + PCW'(cmd.fetch_ofs);
	assign fetch_ok   = fetch_addr < PCW'(MEM_BYTES);
	assign mem_byte   = rvalid_q ? rdata_q : 8'h00;
	assign pc_wide    = {13'd0, pc_q};

	assign stat.run         = run_q;
	assign stat.pc_past_end = pc_q >= PCW'(MEM_BYTES);
	assign stat.clear_last  = clr_cnt_q == AW'(MEM_BYTES - 1);

	always_comb begin
		mem_idx   = fetch_addr[AW-1:0];
		mem_we    = 1'b0;
		mem_wdata = 8'h00;
		if (cmd.clear_mem) begin
			mem_idx = clr_cnt_q;
			mem_we  = 1'b1;
		end else if (cmd.write_byte) begin
			mem_idx   = wr_ext[AW-1:0];
			mem_we    = wr_ok;
			mem_wdata = byte_q;
		end else if (cmd.exec) begin
			mem_idx   = AW'(imm_q);
			mem_we    = (op_q == OP_STB);
			mem_wdata = ra_q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_idx] <= mem_wdata;
		end
		rdata_q <= mem[mem_idx];
	end

	always_comb begin
		case (cmd.rf_sel)
			RF_SEL_A: rf_addr = a_q;
			RF_SEL_B: rf_addr = b_q;
			default:  rf_addr = rsel_q;
		endcase
	end

	assign rf_rd = rf[rf_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf[i] <= '0;
			end
		end else if (cmd.init_state) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf[i] <= '0;
			end
		end else if (cmd.exec) begin
			case (op_q)
				OP_LOAD: rf[a_q] <= {24'd0, imm_q};
				OP_ADD:  rf[a_q] <= ra_q + rb_q;
				OP_SUB:  rf[a_q] <= ra_q - rb_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pc_q      <= '0;
			run_q     <= 1'b1;
			eq_q      <= 1'b0;
			stop_q    <= STAT_RUN;
			rvalid_q  <= 1'b0;
		end else begin
			rvalid_q <= fetch_ok;
			if (cmd.clear_mem) begin
				if (stat.clear_last) begin
					clr_cnt_q <= '0;
				end else begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
				end
			end
			if (cmd.init_state) begin
				pc_q   <= '0;
				run_q  <= 1'b1;
				eq_q   <= 1'b0;
				stop_q <= STAT_RUN;
			end
			if (cmd.stop_past_end) begin
				run_q  <= 1'b0;
				stop_q <= STAT_PAST_END;
			end
			if (cmd.exec) begin
				if (op_q == OP_HALT) begin
					pc_q   <= pc_q + PCW'(1);
					run_q  <= 1'b0;
					stop_q <= STAT_HALT;
				end else begin
					pc_q <= pc_q + PCW'(4);
					case (op_q)
						OP_NOP, OP_LOAD, OP_STB, OP_ADD, OP_SUB: begin
						end
						OP_CMP: begin
							eq_q <= (ra_q == rb_q);
						end
						OP_JE: begin
							if (eq_q) begin
								pc_q <= PCW'(imm_q);
							end
						end
						default: begin
							run_q  <= 1'b0;
							stop_q <= STAT_ILLEGAL;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q <= address;
			byte_q <= byte_data;
			rsel_q <= reg_pick(read_reg_index);
		end
		if (cmd.cap_op) begin
			op_q <= mem_byte;
		end
		if (cmd.cap_a) begin
			a_q <= reg_pick(mem_byte[2:0]);
		end
		if (cmd.cap_b) begin
			b_q <= reg_pick(mem_byte[2:0]);
		end
		if (cmd.cap_imm) begin
			imm_q <= mem_byte;
		end
		if (cmd.cap_ra) begin
			ra_q <= rf_rd;
		end
		if (cmd.cap_rb) begin
			rb_q <= rf_rd;
		end
		if (cmd.load_out) begin
			status_q  <= run_q ? STAT_RUN : stop_q;
			pc_out_q  <= pc_wide[12:0];
			eq_out_q  <= eq_q;
			reg_out_q <= rf_rd;
		end
	end

	assign status     = status_q;
	assign pc_value   = pc_out_q;
	assign equal_flag = eq_out_q;
	assign reg_value  = reg_out_q;

endmodule

`default_nettype wire
